// ----- sv/prqs_pkg.sv -----
// Shared types and constants of the priority ready-queue scheduler.
`default_nettype none
package prqs_pkg;

    // Fixed field widths of the stream payloads
    localparam int MODE_W  = 2;
    localparam int TASK_W  = 6;
    localparam int PRIO_W  = 5;
    localparam int LEVEL_W = 6;   // wide enough for up to 64 priority levels
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 16;

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_MAKE_READY = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CHANGE     = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UNUSED     = 2'd3;

    // Find-first-set result over the ready bitmap
    typedef struct packed {
        logic               found;
        logic [LEVEL_W-1:0] level;
    } ffs_t;

endpackage
`default_nettype wire

// ----- sv/prqs_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module prqs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- sv/prqs_ffs.sv -----
// Find-first-set over the ready bitmap; the lowest set bit is the highest priority.
`default_nettype none
module prqs_ffs
    import prqs_pkg::*;
#(
    parameter int NUM_PRIORITIES = 32
) (
    input  wire logic [NUM_PRIORITIES-1:0] bits,
    output ffs_t                           result
);
    always_comb begin
        result.found = |bits;
        result.level = '0;
        for (int i = NUM_PRIORITIES - 1; i >= 0; i--) begin
            if (bits[i]) begin
                result.level = LEVEL_W'(i);
            end
        end
    end
endmodule
`default_nettype wire

// ----- sv/priority_ready_queue_scheduler.sv -----
// Top level of the priority ready-queue scheduler: sequencer, bitmap and queue memories.
// Usage:
//   The s_ channel carries one kernel operation per transfer: make a task ready,
//   remove a ready task, or change the priority of a ready task. The m_ channel
//   returns one result per operation: the task chosen to run next, whether any
//   task is ready, whether a context switch is needed (change only, gated by the
//   switching_enabled register; cfg_wr_en/cfg_wr_data must write it only while idle,
//   unchecked by the block), and a misuse status. A misused operation changes nothing.
// Operation flow:
//   Each operation walks the queue memories one access per cycle. Misuse goes
//   straight to the result register; make-ready reads the tail and appends; remove
//   unlinks, then searches the bitmap and reads a head when its level empties;
//   change unlinks, appends and may re-pick. One item is in work at a time.
// Reset and stalls:
//   aresetn clears the ready bitmap, the per-task ready bits and the chosen task.
//   The queue and link memories need no clearing. A result waits in the output
//   register while m_tready is low; the next operation is taken meanwhile and
//   holds in its final step until the register frees.
`default_nettype none
module priority_ready_queue_scheduler
    import prqs_pkg::*;
#(
    parameter int NUM_PRIORITIES = 32,
    parameter int NUM_TASKS      = 64
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // tdata: mode[1:0], task_id[7:2], priority_req[12:8], zero[15:13]
    input  wire logic [S_DATA_W-1:0] s_tdata,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // tdata: next_task[5:0], next_valid[6], switch_needed[7], status[8], zero[15:9]
    output logic      [M_DATA_W-1:0] m_tdata,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    input  wire logic                cfg_wr_en,
    input  wire logic                cfg_wr_data
);
    localparam int TW = $clog2(NUM_TASKS);
    localparam int PW = $clog2(NUM_PRIORITIES);

    typedef enum logic [3:0] {
        S_IDLE, S_LOOK, S_UNLINK, S_APP, S_APP_WR, S_APP_WR2, S_PICK, S_PICK2, S_FIN
    } state_t;

    state_t                    state_reg, state_next;
    logic [MODE_W-1:0]         mode_reg, mode_next;
    logic [TW-1:0]             task_reg, task_next;
    logic [PW-1:0]             prio_reg, prio_next;
    logic [PW-1:0]             old_reg, old_next;
    logic [TW-1:0]             nx_reg, nx_next;
    logic [TW-1:0]             pv_reg, pv_next;
    logic [NUM_PRIORITIES-1:0] bitmap_reg, bitmap_next;
    logic [NUM_TASKS-1:0]      ready_reg, ready_next;
    logic                      cv_reg, cv_next;
    logic [TW-1:0]             cid_reg, cid_next;
    logic [PW-1:0]             cprio_reg, cprio_next;
    logic                      sw_reg, sw_next;
    logic                      st_reg, st_next;
    logic                      sw_en_reg;
    logic                      m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0]       m_data_reg, m_data_next;

    // Memory ports
    logic          qh_we, qt_we, ln_we, lp_we, tp_we;
    logic [PW-1:0] qh_waddr, qt_waddr, qh_raddr, qt_raddr;
    logic [TW-1:0] qh_wdata, qt_wdata, qh_rdata, qt_rdata;
    logic [TW-1:0] ln_waddr, lp_waddr, tp_waddr, ln_raddr, lp_raddr, tp_raddr;
    logic [TW-1:0] ln_wdata, lp_wdata, ln_rdata, lp_rdata;
    logic [PW-1:0] tp_wdata, tp_rdata;

    ffs_t ffs_res;

    // Input field decode
    logic [MODE_W-1:0] in_mode;
    logic [TASK_W-1:0] in_task;
    logic [PRIO_W-1:0] in_prio;
    logic [TW-1:0]     in_t;
    logic [PW-1:0]     in_p;
    logic              in_misuse;
    logic              is_head, is_tail;

    assign in_mode = s_tdata[1:0];
    assign in_task = s_tdata[7:2];
    assign in_prio = s_tdata[12:8];
    assign in_t    = TW'(in_task);
    assign in_p    = PW'(in_prio);

    always_comb begin
        in_misuse = 1'b0;
        if (32'(in_task) >= NUM_TASKS || in_mode == MODE_UNUSED) begin
            in_misuse = 1'b1;
        end else if (in_mode == MODE_MAKE_READY) begin
            in_misuse = ready_reg[in_t] || 32'(in_prio) >= NUM_PRIORITIES;
        end else if (in_mode == MODE_REMOVE) begin
            in_misuse = !ready_reg[in_t];
        end else begin
            in_misuse = !ready_reg[in_t] || 32'(in_prio) >= NUM_PRIORITIES;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign is_head = (qh_rdata == task_reg);
    assign is_tail = (qt_rdata == task_reg);

    prqs_ffs #(.NUM_PRIORITIES(NUM_PRIORITIES)) u_ffs (
        .bits   (bitmap_reg),
        .result (ffs_res)
    );

    always_comb begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        task_next    = task_reg;
        prio_next    = prio_reg;
        old_next     = old_reg;
        nx_next      = nx_reg;
        pv_next      = pv_reg;
        bitmap_next  = bitmap_reg;
        ready_next   = ready_reg;
        cv_next      = cv_reg;
        cid_next     = cid_reg;
        cprio_next   = cprio_reg;
        sw_next      = sw_reg;
        st_next      = st_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;

        qh_we = 1'b0; qh_waddr = prio_reg; qh_wdata = task_reg; qh_raddr = prio_reg;
        qt_we = 1'b0; qt_waddr = prio_reg; qt_wdata = task_reg; qt_raddr = prio_reg;
        ln_we = 1'b0; ln_waddr = task_reg; ln_wdata = task_reg; ln_raddr = task_reg;
        lp_we = 1'b0; lp_waddr = task_reg; lp_wdata = task_reg; lp_raddr = task_reg;
        tp_we = 1'b0; tp_waddr = task_reg; tp_wdata = prio_reg; tp_raddr = task_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    mode_next = in_mode;
                    task_next = in_t;
                    prio_next = in_p;
                    sw_next   = 1'b0;
                    st_next   = in_misuse;
                    // Fetch the task's priority and links for remove and change
                    ln_raddr  = in_t;
                    lp_raddr  = in_t;
                    tp_raddr  = in_t;
                    if (in_misuse) begin
                        state_next = S_FIN;
                    end else if (in_mode == MODE_MAKE_READY) begin
                        state_next = S_APP;
                    end else begin
                        state_next = S_LOOK;
                    end
                end
            end
            S_LOOK: begin
                old_next   = tp_rdata;
                nx_next    = ln_rdata;
                pv_next    = lp_rdata;
                qh_raddr   = tp_rdata;
                qt_raddr   = tp_rdata;
                state_next = S_UNLINK;
            end
            S_UNLINK: begin
                // Unlink the task from its old level
                if (is_head && is_tail) begin
                    bitmap_next[old_reg] = 1'b0;
                end else begin
                    if (is_head) begin
                        qh_we = 1'b1; qh_waddr = old_reg; qh_wdata = nx_reg;
                    end else begin
                        ln_we = 1'b1; ln_waddr = pv_reg; ln_wdata = nx_reg;
                    end
                    if (is_tail) begin
                        qt_we = 1'b1; qt_waddr = old_reg; qt_wdata = pv_reg;
                    end else begin
                        lp_we = 1'b1; lp_waddr = nx_reg; lp_wdata = pv_reg;
                    end
                end
                if (mode_reg == MODE_REMOVE) begin
                    ready_next[task_reg] = 1'b0;
                    if (is_head && is_tail) begin
                        state_next = S_PICK;
                    end else begin
                        if (cv_reg && cid_reg == task_reg) begin
                            cid_next = is_head ? nx_reg : qh_rdata;
                        end
                        state_next = S_FIN;
                    end
                end else begin
                    state_next = S_APP;
                end
            end
            S_APP: begin
                qt_raddr   = prio_reg;
                state_next = S_APP_WR;
            end
            S_APP_WR: begin
                // Append at the tail of the new level
                qt_we = 1'b1;
                if (bitmap_reg[prio_reg]) begin
                    lp_we = 1'b1; lp_wdata = qt_rdata;
                    ln_we = 1'b1; ln_waddr = qt_rdata;
                end else begin
                    qh_we = 1'b1;
                    lp_we = 1'b1;
                end
                bitmap_next[prio_reg] = 1'b1;
                state_next = S_APP_WR2;
            end
            S_APP_WR2: begin
                ln_we      = 1'b1;
                tp_we      = 1'b1;
                state_next = S_FIN;
                if (mode_reg == MODE_MAKE_READY) begin
                    ready_next[task_reg] = 1'b1;
                    if (!cv_reg || prio_reg < cprio_reg) begin
                        cv_next    = 1'b1;
                        cid_next   = task_reg;
                        cprio_next = prio_reg;
                    end
                end else if (!cv_reg) begin
                    cv_next    = 1'b1;
                    cid_next   = task_reg;
                    cprio_next = prio_reg;
                    sw_next    = sw_en_reg;
                end else if (cid_reg == task_reg) begin
                    cprio_next = prio_reg;
                    if (prio_reg >= old_reg) begin
                        state_next = S_PICK;
                    end
                end else if (prio_reg < cprio_reg) begin
                    cid_next   = task_reg;
                    cprio_next = prio_reg;
                    sw_next    = sw_en_reg;
                end
            end
            S_PICK: begin
                if (ffs_res.found) begin
                    qh_raddr   = PW'(ffs_res.level);
                    cprio_next = PW'(ffs_res.level);
                    state_next = S_PICK2;
                end else begin
                    cv_next    = 1'b0;
                    cid_next   = '0;
                    state_next = S_FIN;
                end
            end
            S_PICK2: begin
                cv_next  = 1'b1;
                cid_next = qh_rdata;
                if (mode_reg == MODE_CHANGE && qh_rdata != task_reg) begin
                    sw_next = sw_en_reg;
                end
                state_next = S_FIN;
            end
            S_FIN: begin
                // Hold until the output register frees
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '0;
                    m_data_next[5:0] = cv_reg ? TASK_W'(cid_reg) : '0;
                    m_data_next[6]   = cv_reg;
                    m_data_next[7]   = sw_reg;
                    m_data_next[8]   = st_reg;
                    state_next       = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            bitmap_reg  <= '0;
            ready_reg   <= '0;
            cv_reg      <= 1'b0;
            cid_reg     <= '0;
            cprio_reg   <= '0;
            sw_en_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            bitmap_reg  <= bitmap_next;
            ready_reg   <= ready_next;
            cv_reg      <= cv_next;
            cid_reg     <= cid_next;
            cprio_reg   <= cprio_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                sw_en_reg <= cfg_wr_data;
            end
        end
        mode_reg   <= mode_next;
        task_reg   <= task_next;
        prio_reg   <= prio_next;
        old_reg    <= old_next;
        nx_reg     <= nx_next;
        pv_reg     <= pv_next;
        sw_reg     <= sw_next;
        st_reg     <= st_next;
        m_data_reg <= m_data_next;
    end

    prqs_ram #(.WIDTH(TW), .DEPTH(NUM_PRIORITIES)) u_queue_head (
        .aclk(aclk), .we(qh_we), .waddr(qh_waddr), .wdata(qh_wdata),
        .raddr(qh_raddr), .rdata(qh_rdata)
    );
    prqs_ram #(.WIDTH(TW), .DEPTH(NUM_PRIORITIES)) u_queue_tail (
        .aclk(aclk), .we(qt_we), .waddr(qt_waddr), .wdata(qt_wdata),
        .raddr(qt_raddr), .rdata(qt_rdata)
    );
    prqs_ram #(.WIDTH(TW), .DEPTH(NUM_TASKS)) u_link_next (
        .aclk(aclk), .we(ln_we), .waddr(ln_waddr), .wdata(ln_wdata),
        .raddr(ln_raddr), .rdata(ln_rdata)
    );
    prqs_ram #(.WIDTH(TW), .DEPTH(NUM_TASKS)) u_link_prev (
        .aclk(aclk), .we(lp_we), .waddr(lp_waddr), .wdata(lp_wdata),
        .raddr(lp_raddr), .rdata(lp_rdata)
    );
    prqs_ram #(.WIDTH(PW), .DEPTH(NUM_TASKS)) u_task_prio (
        .aclk(aclk), .we(tp_we), .waddr(tp_waddr), .wdata(tp_wdata),
        .raddr(tp_raddr), .rdata(tp_rdata)
    );
endmodule
`default_nettype wire
